/* rtl/swsfr_pkg.sv */
`default_nettype none

package swsfr_pkg;

    // Sequence numbers and window
    localparam int unsigned SEQ_BITS      = 3;
    localparam int unsigned SEQ_DEPTH     = 1 << SEQ_BITS;
    localparam int unsigned DUP_THRESHOLD = 3;
    localparam int unsigned DUP_BITS      = 2;

    localparam int unsigned PAYLOAD_BITS  = 64;
    localparam int unsigned WIN_BITS      = 3;

    typedef logic [SEQ_BITS-1:0]     t_seq;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [WIN_BITS-1:0]     t_win;
    typedef logic [DUP_BITS-1:0]     t_dup;

    localparam t_seq SEQ_MASK = t_seq'(SEQ_DEPTH - 1);

    // Item kinds
    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // Transmit reasons
    localparam logic [1:0] REASON_NEW     = 2'd0;
    localparam logic [1:0] REASON_FAST    = 2'd1;
    localparam logic [1:0] REASON_TIMEOUT = 2'd2;

    // Timer actions
    localparam logic [1:0] TIMER_KEEP  = 2'd0;
    localparam logic [1:0] TIMER_START = 2'd1;
    localparam logic [1:0] TIMER_STOP  = 2'd2;

    typedef struct packed {
        logic       send_accepted;
        logic       transmit;
        logic [1:0] transmit_reason;
        logic [2:0] tx_sequence;
        t_payload   tx_payload;
        logic [1:0] timer_action;
        logic [2:0] window_base;
        logic [2:0] outstanding;
    } t_result;

endpackage

`default_nettype wire

/* rtl/swsfr_if.sv */
`default_nettype none

// Event channel: send, ack or timeout
interface swsfr_in_if;
    import swsfr_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    t_payload   payload_word;
    logic [2:0] ack_number;
    logic       ack_check_ok;

    modport source (output valid, output kind, output payload_word,
                    output ack_number, output ack_check_ok, input ready);
    modport sink   (input valid, input kind, input payload_word,
                    input ack_number, input ack_check_ok, output ready);
endinterface

// Result channel: one result per event
interface swsfr_out_if;
    import swsfr_pkg::*;

    logic       valid;
    logic       ready;
    logic       send_accepted;
    logic       transmit;
    logic [1:0] transmit_reason;
    logic [2:0] tx_sequence;
    t_payload   tx_payload;
    logic [1:0] timer_action;
    logic [2:0] window_base;
    logic [2:0] outstanding;

    modport source (output valid, output send_accepted, output transmit,
                    output transmit_reason, output tx_sequence, output tx_payload,
                    output timer_action, output window_base, output outstanding,
                    input ready);
    modport sink   (input valid, input send_accepted, input transmit,
                    input transmit_reason, input tx_sequence, input tx_payload,
                    input timer_action, input window_base, input outstanding,
                    output ready);
endinterface

`default_nettype wire

/* rtl/sliding_window_sender_fast_retransmit.sv */
// Go-back-N sender with one timer and fast retransmit.
// i_item carries one event per transfer: a send with its 64-bit payload word,
// an ack with its cumulative number and checksum flag, or a timer expiry.
// o_result returns exactly one result per event: whether a send was taken,
// whether a packet goes out (new, fast retransmit or timeout retransmit),
// its sequence number and payload, the timer action, and the window base and
// occupancy after the event.
// The window update and the payload store access happen in the cycle the event
// is transferred, and the result register holds the answer from the next cycle on.
// Throughput is one event per cycle while the receiver takes each result; the
// single result register sets that figure.
// While the receiver stalls a held result, i_item.ready drops and no event
// is taken; it rises again in the cycle the result is transferred.
// i_cfg_we / i_cfg_data write window_size; write it only while idle.
// Synchronous active-low reset empties the window, clears the duplicate
// count, sets window_size to 4 and drops o_result.valid. The payload store
// is not cleared; only entries written by a send are ever read.
`default_nettype none

module sliding_window_sender_fast_retransmit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    swsfr_in_if.sink                 i_item,
    swsfr_out_if.source              o_result,
    input  wire                      i_cfg_we,
    input  wire swsfr_pkg::t_win     i_cfg_data
);
    import swsfr_pkg::*;

    // Window state
    t_seq     r_base, n_base;
    t_seq     r_next, n_next;
    t_seq     r_in_flight, n_in_flight;
    t_dup     r_dup, n_dup;
    t_win     r_window_size;

    // Payload store
    t_payload r_store [SEQ_DEPTH];
    logic     store_we;

    // Result register
    logic     r_out_valid;
    t_result  r_result, n_result;
    logic     tx_from_store;
    logic     r_from_store;
    t_payload r_stored_payload;

    logic     accept;
    t_win     win;
    t_seq     dup_seq;
    t_seq     offset;
    logic [DUP_BITS:0] dup_inc;

    // Take an event whenever the result register is free or being drained
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    // Event decode and window update
    always_comb begin
        win      = (r_window_size > t_win'(SEQ_MASK)) ? t_win'(SEQ_MASK) : r_window_size;
        dup_seq  = r_base - t_seq'(1);
        offset   = t_seq'(i_item.ack_number) - r_base;
        dup_inc  = {1'b0, r_dup} + {{DUP_BITS{1'b0}}, 1'b1};

        n_base        = r_base;
        n_next        = r_next;
        n_in_flight   = r_in_flight;
        n_dup         = r_dup;
        store_we      = 1'b0;
        tx_from_store = 1'b0;
        n_result      = '0;

        unique case (i_item.kind)
            KIND_SEND: begin
                if (t_win'(r_in_flight) < win) begin
                    store_we                 = 1'b1;
                    n_result.send_accepted   = 1'b1;
                    n_result.transmit        = 1'b1;
                    n_result.transmit_reason = REASON_NEW;
                    n_result.tx_sequence     = 3'(r_next);
                    n_result.tx_payload      = i_item.payload_word;
                    if (r_in_flight == '0) begin
                        n_result.timer_action = TIMER_START;
                    end
                    n_next      = r_next + t_seq'(1);
                    n_in_flight = r_in_flight + t_seq'(1);
                end
            end
            KIND_ACK: begin
                if (i_item.ack_check_ok) begin
                    if (t_seq'(i_item.ack_number) == dup_seq) begin
                        // Count duplicates; retransmit the oldest on threshold
                        if (dup_inc >= (DUP_BITS+1)'(DUP_THRESHOLD)) begin
                            n_dup = '0;
                            if (r_in_flight != '0) begin
                                n_result.transmit        = 1'b1;
                                n_result.transmit_reason = REASON_FAST;
                                n_result.tx_sequence     = 3'(r_base);
                                tx_from_store            = 1'b1;
                            end
                        end else begin
                            n_dup = dup_inc[DUP_BITS-1:0];
                        end
                    end else if (offset < r_in_flight) begin
                        // Slide the base past the acked number
                        n_base      = t_seq'(i_item.ack_number) + t_seq'(1);
                        n_in_flight = r_in_flight - offset - t_seq'(1);
                        n_dup       = '0;
                        n_result.timer_action = (n_in_flight != '0) ? TIMER_START
                                                                    : TIMER_STOP;
                    end
                end
            end
            KIND_TIMEOUT: begin
                if (r_in_flight != '0) begin
                    n_result.transmit        = 1'b1;
                    n_result.transmit_reason = REASON_TIMEOUT;
                    n_result.tx_sequence     = 3'(r_base);
                    tx_from_store            = 1'b1;
                    n_result.timer_action    = TIMER_START;
                end
            end
            default: begin
            end
        endcase

        n_result.window_base = 3'(n_base);
        n_result.outstanding = 3'(n_in_flight);
    end

    // Hold window state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= '0;
            r_next        <= '0;
            r_in_flight   <= '0;
            r_dup         <= '0;
            r_window_size <= t_win'(4);
        end else begin
            if (i_cfg_we) begin
                r_window_size <= i_cfg_data;
            end
            if (accept) begin
                r_base      <= n_base;
                r_next      <= n_next;
                r_in_flight <= n_in_flight;
                r_dup       <= n_dup;
            end
        end
    end

    // Store the payload of an accepted send
    always_ff @(posedge i_clk) begin
        if (accept && store_we) begin
            r_store[r_next] <= i_item.payload_word;
        end
    end

    // Load the result register on accept, drop it when transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Register the result; read the oldest stored payload for a retransmit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result         <= n_result;
            r_from_store     <= tx_from_store;
            r_stored_payload <= r_store[r_base];
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.send_accepted   = r_result.send_accepted;
    assign o_result.transmit        = r_result.transmit;
    assign o_result.transmit_reason = r_result.transmit_reason;
    assign o_result.tx_sequence     = r_result.tx_sequence;
    assign o_result.tx_payload      = r_from_store ? r_stored_payload : r_result.tx_payload;
    assign o_result.timer_action    = r_result.timer_action;
    assign o_result.window_base     = r_result.window_base;
    assign o_result.outstanding     = r_result.outstanding;

endmodule

`default_nettype wire

/* test/tb_sliding_window_sender_fast_retransmit.sv */
`default_nettype none

module tb_sliding_window_sender_fast_retransmit;
    timeunit 1ns;
    timeprecision 1ps;

    import swsfr_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam t_win       WINDOW_AT_RESET = t_win'(4);
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         LONG_HOLD       = 300;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         REPORT_LIMIT    = 10;

    typedef struct {
        logic [1:0] kind;
        t_payload   payload;
        t_seq       ack;
        logic       check_ok;
    } t_net_event;

    typedef struct {
        t_win        win;
        t_seq        base;
        t_seq        next;
        int unsigned in_flight;
        int unsigned dup_count;
        t_payload    store [SEQ_DEPTH];
    } t_sender_state;

    logic clk;
    logic rst_n    = 1'b0;
    logic cfg_we   = 1'b0;
    t_win cfg_data = '0;

    swsfr_in_if  ev_ch ();
    swsfr_out_if res_ch ();

    sliding_window_sender_fast_retransmit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (ev_ch),
        .o_result   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Window state as seen by the checker (live) and by the stimulus planner
    t_sender_state live_state;
    t_sender_state plan_state;

    t_net_event pending_events [$];
    t_result    expected_results [$];
    t_net_event offered;

    bit   idle_on      = 1'b1;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    logic hold_request = 1'b0;
    int   fail_count   = 0;
    int   result_count = 0;
    int   cycle_count  = 0;

    // Advance the sender by one event and return the result it must report
    function automatic t_result step_window(ref t_sender_state st, input t_net_event ev);
        t_result     r;
        int unsigned limit;
        t_seq        dup_seq;
        t_seq        offset;
        r = '0;
        limit = (st.win > SEQ_DEPTH - 1) ? SEQ_DEPTH - 1 : st.win;
        case (ev.kind)
            KIND_SEND: begin
                if (st.in_flight < limit) begin
                    st.store[st.next] = ev.payload;
                    r.send_accepted   = 1'b1;
                    r.transmit        = 1'b1;
                    r.transmit_reason = REASON_NEW;
                    r.tx_sequence     = st.next;
                    r.tx_payload      = ev.payload;
                    if (st.in_flight == 0)
                        r.timer_action = TIMER_START;
                    st.next = st.next + 1'b1;
                    st.in_flight++;
                end
            end
            KIND_ACK: begin
                if (ev.check_ok) begin
                    dup_seq = st.base - 1'b1;
                    offset  = ev.ack - st.base;
                    if (ev.ack == dup_seq) begin
                        // Every third duplicate resends the oldest packet if any is in flight
                        st.dup_count++;
                        if (st.dup_count >= DUP_THRESHOLD) begin
                            st.dup_count = 0;
                            if (st.in_flight != 0) begin
                                r.transmit        = 1'b1;
                                r.transmit_reason = REASON_FAST;
                                r.tx_sequence     = st.base;
                                r.tx_payload      = st.store[st.base];
                            end
                        end
                    end else if (offset < st.in_flight) begin
                        // Slide the base past the acked number
                        st.base       = ev.ack + 1'b1;
                        st.in_flight -= offset + 1;
                        st.dup_count  = 0;
                        r.timer_action = (st.in_flight != 0) ? TIMER_START : TIMER_STOP;
                    end
                end
            end
            KIND_TIMEOUT: begin
                if (st.in_flight != 0) begin
                    r.transmit        = 1'b1;
                    r.transmit_reason = REASON_TIMEOUT;
                    r.tx_sequence     = st.base;
                    r.tx_payload      = st.store[st.base];
                    r.timer_action    = TIMER_START;
                end
            end
            default: ;
        endcase
        r.window_base = st.base;
        r.outstanding = 3'(st.in_flight);
        return r;
    endfunction

    function automatic string describe(t_result r);
        return $sformatf("acc=%0b tx=%0b reason=%0d seq=%0d payload=%h timer=%0d base=%0d out=%0d",
                         r.send_accepted, r.transmit, r.transmit_reason, r.tx_sequence,
                         r.tx_payload, r.timer_action, r.window_base, r.outstanding);
    endfunction

    function automatic t_payload random_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Queue one event and advance the planner so later acks can target the window
    task automatic queue_event(input logic [1:0] kind, input t_payload payload,
                               input t_seq ack, input logic check_ok);
        t_net_event ev;
        ev.kind     = kind;
        ev.payload  = payload;
        ev.ack      = ack;
        ev.check_ok = check_ok;
        pending_events.insert(pending_events.size(), ev);
        void'(step_window(plan_state, ev));
    endtask

    // Mostly well-formed traffic: sends, in-window acks, duplicate triples,
    // timeouts; the rest stray acks, bad checksums and the unused kind
    task automatic queue_traffic(input int count);
        int   made;
        int   pick;
        int   k;
        t_seq ack;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                queue_event(KIND_SEND, random_payload(), t_seq'($urandom), 1'($urandom));
                made++;
            end else if (pick < 66) begin
                if (plan_state.in_flight != 0)
                    ack = plan_state.base + t_seq'($urandom_range(0, plan_state.in_flight - 1));
                else
                    ack = plan_state.base - 1'b1;
                queue_event(KIND_ACK, random_payload(), ack, 1'b1);
                made++;
            end else if (pick < 78) begin
                for (k = 0; k < DUP_THRESHOLD; k++)
                    queue_event(KIND_ACK, random_payload(), plan_state.base - 1'b1, 1'b1);
                made += DUP_THRESHOLD;
            end else if (pick < 86) begin
                queue_event(KIND_TIMEOUT, random_payload(), t_seq'($urandom), 1'($urandom));
                made++;
            end else if (pick < 92) begin
                queue_event(KIND_ACK, random_payload(), t_seq'($urandom), 1'b1);
                made++;
            end else if (pick < 96) begin
                queue_event(KIND_ACK, random_payload(), t_seq'($urandom), 1'b0);
                made++;
            end else begin
                queue_event(KIND_UNUSED, random_payload(), t_seq'($urandom), 1'($urandom));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_events.size() != 0 || expected_results.size() != 0 || ev_ch.valid);
    endtask

    // Write window_size while nothing is in transfer
    task automatic write_window(input t_win value);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        live_state.win = value;
        plan_state.win = value;
    endtask

    task automatic hold_receiver();
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
    endtask

    task automatic set_idling(input int send_gap_pct, input int recv_stall_pct);
        @(posedge clk);
        idle_pct  <= send_gap_pct;
        stall_pct <= recv_stall_pct;
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Event driver: hold each item until transferred, with random gaps between items
    always @(posedge clk) begin : drive_events
        t_net_event ev;
        if (!rst_n) begin
            ev_ch.valid <= 1'b0;
            gap_left     = 0;
        end else begin
            if (ev_ch.valid && ev_ch.ready)
                expected_results.insert(expected_results.size(),
                                        step_window(live_state, offered));
            if (!ev_ch.valid || ev_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    ev_ch.valid <= 1'b0;
                end else if (pending_events.size() != 0 && idle_on &&
                             $urandom_range(0, 99) < idle_pct) begin
                    gap_left     = $urandom_range(0, 10);
                    ev_ch.valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    ev       = pending_events[0];
                    pending_events.delete(0);
                    offered  = ev;
                    ev_ch.kind         <= ev.kind;
                    ev_ch.payload_word <= ev.payload;
                    ev_ch.ack_number   <= ev.ack;
                    ev_ch.ack_check_ok <= ev.check_ok;
                    ev_ch.valid        <= 1'b1;
                end else begin
                    ev_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_request)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: check each transfer against the oldest expectation
    always @(posedge clk) begin : check_results
        t_result got;
        t_result want;
        logic    rdy;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.send_accepted   = res_ch.send_accepted;
                got.transmit        = res_ch.transmit;
                got.transmit_reason = res_ch.transmit_reason;
                got.tx_sequence     = res_ch.tx_sequence;
                got.tx_payload      = res_ch.tx_payload;
                got.timer_action    = res_ch.timer_action;
                got.window_base     = res_ch.window_base;
                got.outstanding     = res_ch.outstanding;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d with nothing expected: %s",
                                 result_count, describe(got));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.send_accepted   !== want.send_accepted   ||
                        got.transmit        !== want.transmit        ||
                        got.transmit_reason !== want.transmit_reason ||
                        got.tx_sequence     !== want.tx_sequence     ||
                        got.tx_payload      !== want.tx_payload      ||
                        got.timer_action    !== want.timer_action    ||
                        got.window_base     !== want.window_base     ||
                        got.outstanding     !== want.outstanding) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("result %0d mismatch\n  expected %s\n  actual   %s",
                                     result_count, describe(want), describe(got));
                    end
                end
                result_count++;
            end
            // Stall in random bursts unless idling is off
            if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 10);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            res_ch.ready <= rdy && (hold_left == 0);
        end
    end

    // Cycle limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sliding_window_sender_fast_retransmit verification failed");
            $finish;
        end
    end

    initial begin
        ev_ch.valid        = 1'b0;
        ev_ch.kind         = KIND_SEND;
        ev_ch.payload_word = '0;
        ev_ch.ack_number   = '0;
        ev_ch.ack_check_ok = 1'b0;
        res_ch.ready       = 1'b0;

        live_state.win       = WINDOW_AT_RESET;
        live_state.base      = '0;
        live_state.next      = '0;
        live_state.in_flight = 0;
        live_state.dup_count = 0;
        plan_state = live_state;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-window events, fill to the reset window, refusal,
        // ignored acks, fast and timeout retransmit, cumulative acks, wrap
        set_idling(30, 30);
        queue_event(KIND_TIMEOUT, '1, 3'd7, 1'b1);
        repeat (3) queue_event(KIND_ACK, '0, 3'd7, 1'b1);
        queue_event(KIND_SEND, '1, 3'd0, 1'b0);
        queue_event(KIND_SEND, '0, 3'd0, 1'b1);
        queue_event(KIND_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0);
        queue_event(KIND_SEND, 64'h5555_5555_5555_5555, 3'd0, 1'b0);
        queue_event(KIND_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 1'b0);
        queue_event(KIND_ACK, '0, 3'd1, 1'b0);
        queue_event(KIND_ACK, '0, 3'd5, 1'b1);
        repeat (3) queue_event(KIND_ACK, '0, 3'd7, 1'b1);
        queue_event(KIND_TIMEOUT, '0, 3'd0, 1'b0);
        queue_event(KIND_ACK, '0, 3'd0, 1'b1);
        queue_event(KIND_ACK, '0, 3'd3, 1'b1);
        queue_event(KIND_UNUSED, random_payload(), t_seq'($urandom), 1'b1);
        repeat (3) queue_event(KIND_SEND, random_payload(), 3'd0, 1'b0);
        queue_event(KIND_ACK, '0, 3'd6, 1'b1);
        repeat (2) queue_event(KIND_SEND, random_payload(), 3'd0, 1'b0);
        queue_event(KIND_ACK, '0, 3'd0, 1'b1);

        // Widest window, with a long receiver hold-off while items keep coming
        write_window(t_win'(7));
        queue_traffic(200);
        hold_receiver();

        write_window(t_win'(1));
        set_idling(40, 15);
        queue_traffic(100);

        // Zero window refuses every send
        write_window(t_win'(0));
        queue_traffic(40);

        // Lower the window below the packets in flight
        write_window(t_win'(7));
        repeat (6) queue_event(KIND_SEND, random_payload(), 3'd0, 1'b0);
        write_window(t_win'(2));
        queue_traffic(120);

        // Stretch without idling
        write_window(t_win'(5));
        set_idling(0, 0);
        queue_traffic(150);

        write_window(t_win'(3));
        set_idling(50, 50);
        queue_traffic(150);
        hold_receiver();

        // Last part runs back to back
        write_window(t_win'(6));
        idle_on <= 1'b0;
        queue_traffic(150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_results.size();
        if (fail_count == 0)
            $display("sliding_window_sender_fast_retransmit verification clean");
        else
            $display("sliding_window_sender_fast_retransmit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
